@@ src/congestion_bitrate_governor_unit_assert.svh @@
// Assertion macros for the checker file of the rate governor.
// Every assertion is clocked on clk_i and switched off while rst_ni is low.
`ifndef CONGESTION_BITRATE_GOVERNOR_UNIT_ASSERT_SVH
`define CONGESTION_BITRATE_GOVERNOR_UNIT_ASSERT_SVH

// Checks a property in the same cycle.
`define CBGU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another condition in the next cycle.
`define CBGU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/cbg_pkg.sv @@
`timescale 1ns / 1ps
package cbg_pkg;

  localparam int unsigned TimeBits    = 32;
  localparam int unsigned RateBits    = 18;
  localparam int unsigned LevelBits   = 16;
  localparam int unsigned MsBits      = 16;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned InDataBits  = 104;
  localparam int unsigned InUserBits  = 2;
  localparam int unsigned OutDataBits = 48;

  typedef logic [TimeBits-1:0] stamp_t;
  typedef logic [RateBits-1:0] rate_t;

  // Link state codes
  localparam logic [2:0] LinkIdle      = 3'd0;
  localparam logic [2:0] LinkHealthy   = 3'd1;
  localparam logic [2:0] LinkDegrading = 3'd2;
  localparam logic [2:0] LinkAtFloor   = 3'd3;
  localparam logic [2:0] LinkBreaking  = 3'd4;

  // Decision codes
  localparam logic [1:0] DecHold = 2'd0;
  localparam logic [1:0] DecDown = 2'd1;
  localparam logic [1:0] DecUp   = 2'd2;

  // Break event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvEnter = 2'd1;
  localparam logic [1:0] EvExit  = 2'd2;

  // Command codes
  localparam logic [1:0] CmdPoll  = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdStop  = 2'd2;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] CfgLowerFloor = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgDegradeThr = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgBreakThr   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgBreakHold  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgDownIvl    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgUpIvl      = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgRecovery   = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgStep       = 3'd7;

  localparam rate_t MinFloor = 18'd100;

  typedef struct packed {
    rate_t               lower_floor;
    logic [LevelBits-1:0] degrade_thr;
    logic [LevelBits-1:0] break_thr;
    logic [MsBits-1:0]    break_hold;
    logic [MsBits-1:0]    down_ivl;
    logic [MsBits-1:0]    up_ivl;
    logic [MsBits-1:0]    recovery;
    logic [MsBits-1:0]    step;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    lower_floor: 18'd0,
    degrade_thr: 16'd16384,
    break_thr:   16'd29491,
    break_hold:  16'd3000,
    down_ivl:    16'd2000,
    up_ivl:      16'd5000,
    recovery:    16'd10000,
    step:        16'd500
  };

  typedef struct packed {
    logic [1:0]           cmd;
    logic [31:0]          now_ms;
    logic [LevelBits-1:0] congestion;
    rate_t                ceiling_kbps;
    rate_t                encoder_kbps;
    rate_t                encoder_nominal_kbps;
    logic                 adapt_enable;
  } item_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic [1:0] decision;
    rate_t      new_kbps;
    rate_t      floor_kbps_out;
    logic [1:0] break_event;
  } res_t;

  // Wrapping time difference.
  function automatic stamp_t elapsed(stamp_t now, stamp_t then);
    return now - then;
  endfunction

endpackage

@@ src/cbg_cfg.sv @@
`timescale 1ns / 1ps
module cbg_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbg_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [cbg_pkg::RateBits-1:0]     cfg_wdata_i,
  output cbg_pkg::cfg_t                    cfg_o
);

  cbg_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbg_pkg::CfgLowerFloor: cfg_d.lower_floor = cfg_wdata_i;
        cbg_pkg::CfgDegradeThr: cfg_d.degrade_thr = cfg_wdata_i[cbg_pkg::LevelBits-1:0];
        cbg_pkg::CfgBreakThr:   cfg_d.break_thr   = cfg_wdata_i[cbg_pkg::LevelBits-1:0];
        cbg_pkg::CfgBreakHold:  cfg_d.break_hold  = cfg_wdata_i[cbg_pkg::MsBits-1:0];
        cbg_pkg::CfgDownIvl:    cfg_d.down_ivl    = cfg_wdata_i[cbg_pkg::MsBits-1:0];
        cbg_pkg::CfgUpIvl:      cfg_d.up_ivl      = cfg_wdata_i[cbg_pkg::MsBits-1:0];
        cbg_pkg::CfgRecovery:   cfg_d.recovery    = cfg_wdata_i[cbg_pkg::MsBits-1:0];
        cbg_pkg::CfgStep:       cfg_d.step        = cfg_wdata_i[cbg_pkg::MsBits-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cbg_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/cbg_core.sv @@
`timescale 1ns / 1ps
module cbg_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  cbg_pkg::item_t item_i,
  input  cbg_pkg::cfg_t  cfg_i,
  output cbg_pkg::res_t  res_o
);

  logic [2:0]      state_d, state_q;
  cbg_pkg::rate_t  floor_d, floor_q;
  cbg_pkg::stamp_t last_down_d, last_down_q;
  cbg_pkg::stamp_t last_up_d, last_up_q;
  cbg_pkg::stamp_t healthy_d, healthy_q;
  cbg_pkg::stamp_t break_d, break_q;
  logic            announced_d, announced_q;

  cbg_pkg::stamp_t t;
  cbg_pkg::rate_t  cur;
  cbg_pkg::rate_t  half_ceil;
  cbg_pkg::rate_t  floor_lim;
  cbg_pkg::rate_t  floor_calc;
  cbg_pkg::rate_t  floor_poll;
  logic            ceil_set;
  logic            above_deg;
  logic            above_brk;
  logic            cur_low;
  cbg_pkg::stamp_t break_eff;
  logic            break_held;
  logic [2:0]      ns;
  cbg_pkg::stamp_t healthy_mid;
  cbg_pkg::stamp_t healthy_eff;
  logic            down_ok;
  logic            up_ok;
  logic            recovered;
  logic            ns_congested;
  cbg_pkg::rate_t  step_ext;
  cbg_pkg::rate_t  down_rate;
  logic [cbg_pkg::RateBits:0] up_sum;
  cbg_pkg::rate_t  up_rate;

  assign t   = item_i.now_ms[cbg_pkg::TimeBits-1:0];
  assign cur = (item_i.encoder_kbps != '0) ? item_i.encoder_kbps : item_i.encoder_nominal_kbps;

  // Floor is the largest of half the ceiling, the configured lower limit and the minimum; without a ceiling it holds.
  assign ceil_set   = item_i.ceiling_kbps != '0;
  assign half_ceil  = item_i.ceiling_kbps >> 1;
  assign floor_lim  = (half_ceil < cfg_i.lower_floor) ? cfg_i.lower_floor : half_ceil;
  assign floor_calc = (floor_lim < cbg_pkg::MinFloor) ? cbg_pkg::MinFloor : floor_lim;
  assign floor_poll = ceil_set ? floor_calc : floor_q;

  assign above_deg = item_i.congestion >= cfg_i.degrade_thr;
  assign above_brk = item_i.congestion >= cfg_i.break_thr;
  assign cur_low   = cur <= floor_poll;

  assign break_eff  = (break_q == '0) ? t : break_q;
  assign break_held = cbg_pkg::elapsed(t, break_eff) >= cbg_pkg::TimeBits'(cfg_i.break_hold);

  always_comb begin
    priority if (state_q == cbg_pkg::LinkIdle) begin
      ns = cbg_pkg::LinkHealthy;
    end else if (above_brk && cur_low) begin
      ns = break_held ? cbg_pkg::LinkBreaking : cbg_pkg::LinkAtFloor;
    end else if (cur_low && above_deg) begin
      ns = cbg_pkg::LinkAtFloor;
    end else if (above_deg) begin
      ns = cbg_pkg::LinkDegrading;
    end else begin
      ns = cbg_pkg::LinkHealthy;
    end
  end

  assign healthy_mid = (state_q == cbg_pkg::LinkIdle) ? t : healthy_q;
  assign healthy_eff = (healthy_mid == '0) ? t : healthy_mid;

  assign down_ok = (last_down_q == '0) ||
                   (cbg_pkg::elapsed(t, last_down_q) >= cbg_pkg::TimeBits'(cfg_i.down_ivl));
  assign up_ok   = (last_up_q == '0) ||
                   (cbg_pkg::elapsed(t, last_up_q) >= cbg_pkg::TimeBits'(cfg_i.up_ivl));
  assign recovered = cbg_pkg::elapsed(t, healthy_eff) >= cbg_pkg::TimeBits'(cfg_i.recovery);

  assign ns_congested = (ns == cbg_pkg::LinkDegrading) || (ns == cbg_pkg::LinkAtFloor) ||
                        (ns == cbg_pkg::LinkBreaking);

  // A step down never goes below the floor; a step up never goes above the ceiling.
  assign step_ext  = cbg_pkg::RateBits'(cfg_i.step);
  assign down_rate = ((cur - floor_poll) > step_ext) ? (cur - step_ext) : floor_poll;
  assign up_sum    = {1'b0, cur} + {1'b0, step_ext};
  assign up_rate   = (up_sum > {1'b0, item_i.ceiling_kbps}) ? item_i.ceiling_kbps
                                                           : up_sum[cbg_pkg::RateBits-1:0];

  always_comb begin
    state_d     = state_q;
    floor_d     = floor_q;
    last_down_d = last_down_q;
    last_up_d   = last_up_q;
    healthy_d   = healthy_q;
    break_d     = break_q;
    announced_d = announced_q;
    res_o.decision    = cbg_pkg::DecHold;
    res_o.new_kbps    = cur;
    res_o.break_event = cbg_pkg::EvNone;

    unique case (item_i.cmd)
      cbg_pkg::CmdStart: begin
        last_down_d = '0;
        last_up_d   = '0;
        healthy_d   = t;
        break_d     = '0;
        announced_d = 1'b0;
        state_d     = cbg_pkg::LinkHealthy;
      end
      cbg_pkg::CmdStop: begin
        state_d = cbg_pkg::LinkIdle;
      end
      cbg_pkg::CmdPoll: begin
        floor_d   = floor_poll;
        state_d   = ns;
        healthy_d = healthy_mid;
        if (state_q != cbg_pkg::LinkIdle) begin
          break_d = (above_brk && cur_low) ? break_eff : '0;
        end

        if (item_i.adapt_enable && ceil_set) begin
          if (ns_congested && (cur > floor_poll) && down_ok) begin
            res_o.new_kbps = down_rate;
            res_o.decision = cbg_pkg::DecDown;
            last_down_d    = t;
          end else if ((ns == cbg_pkg::LinkHealthy) && (cur < item_i.ceiling_kbps)) begin
            healthy_d = healthy_eff;
            if (recovered && up_ok) begin
              res_o.new_kbps = up_rate;
              res_o.decision = cbg_pkg::DecUp;
              last_up_d      = t;
            end
          end else if (ns != cbg_pkg::LinkHealthy) begin
            healthy_d = '0;
          end
        end

        if ((ns == cbg_pkg::LinkBreaking) && !announced_q) begin
          announced_d       = 1'b1;
          res_o.break_event = cbg_pkg::EvEnter;
        end else if ((ns != cbg_pkg::LinkBreaking) && announced_q) begin
          announced_d       = 1'b0;
          res_o.break_event = cbg_pkg::EvExit;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase

    res_o.link_state     = state_d;
    res_o.floor_kbps_out = floor_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbg_pkg::LinkIdle;
      floor_q     <= '0;
      last_down_q <= '0;
      last_up_q   <= '0;
      healthy_q   <= '0;
      break_q     <= '0;
      announced_q <= 1'b0;
    end else if (fire_i) begin
      state_q     <= state_d;
      floor_q     <= floor_d;
      last_down_q <= last_down_d;
      last_up_q   <= last_up_d;
      healthy_q   <= healthy_d;
      break_q     <= break_d;
      announced_q <= announced_d;
    end
  end

endmodule

@@ src/congestion_bitrate_governor_unit.sv @@
`timescale 1ns / 1ps
// Rate governor for a streaming encoder under link congestion.
// Input channel (s_axis): one beat per poll tick or stream event. tuser carries the
// command (poll, stream started, stream stopping); tdata carries the timestamp,
// congestion level, ceiling, encoder rates and the adapt enable bit.
// Output channel (m_axis): exactly one beat for every input beat, in order, with the
// link state, the decision, the rate to apply, the floor and the break event.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the clock
// edge; write only while no beat is in flight.
// Path: an accepted beat is held in the input register, then its result in the result
// register, which drives m_axis. Throughput: one beat per cycle while m_axis does not
// stall; combinational logic between the two registers reads and updates the state.
// Reset: the link state goes to idle, the floor and all timers clear, and the
// registers take their default values; no beats are held.
// When m_axis stalls, the result register holds and the input register still
// takes one more beat; s_axis_tready then drops until the result is taken.
module congestion_bitrate_governor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cbg_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [cbg_pkg::RateBits-1:0]       cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] now_ms, [47:32] congestion, [65:48] ceiling_kbps, [83:66] encoder_kbps,
  // [101:84] encoder_nominal_kbps, [102] adapt_enable, [103] zero
  input  logic [cbg_pkg::InDataBits-1:0]     s_axis_tdata,
  // [1:0] cmd
  input  logic [cbg_pkg::InUserBits-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] link_state, [4:3] decision, [22:5] new_kbps, [40:23] floor_kbps_out,
  // [42:41] break_event, [47:43] zero
  output logic [cbg_pkg::OutDataBits-1:0]    m_axis_tdata
);

  cbg_pkg::cfg_t  cfg;
  cbg_pkg::item_t in_item;
  cbg_pkg::item_t item_q;
  cbg_pkg::res_t  res;
  cbg_pkg::res_t  res_q;
  logic           in_valid_d, in_valid_q;
  logic           out_valid_d, out_valid_q;
  logic           s_fire;
  logic           advance;

  assign in_item.cmd                  = s_axis_tuser[1:0];
  assign in_item.now_ms               = s_axis_tdata[31:0];
  assign in_item.congestion           = s_axis_tdata[47:32];
  assign in_item.ceiling_kbps         = s_axis_tdata[65:48];
  assign in_item.encoder_kbps         = s_axis_tdata[83:66];
  assign in_item.encoder_nominal_kbps = s_axis_tdata[101:84];
  assign in_item.adapt_enable         = s_axis_tdata[102];

  // The held beat is processed whenever the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  cbg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cbg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= in_item;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.break_event, res_q.floor_kbps_out, res_q.new_kbps,
                          res_q.decision, res_q.link_state};

endmodule

@@ src/cbg_checker.sv @@
`timescale 1ns / 1ps
`include "congestion_bitrate_governor_unit_assert.svh"
module cbg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cbg_pkg::OutDataBits-1:0] m_axis_tdata
);

  logic [2:0]     link_state;
  logic [1:0]     decision;
  cbg_pkg::rate_t new_kbps;
  cbg_pkg::rate_t floor_rate;
  logic [1:0]     break_event;
  logic           stalled;
  logic           down_clamped;
  logic           up_healthy;
  logic           event_consistent;

  assign link_state  = m_axis_tdata[2:0];
  assign decision    = m_axis_tdata[4:3];
  assign new_kbps    = m_axis_tdata[22:5];
  assign floor_rate  = m_axis_tdata[40:23];
  assign break_event = m_axis_tdata[42:41];

  assign stalled = m_axis_tvalid && !m_axis_tready;

  // A step down is clamped at the floor reported in the same beat.
  assign down_clamped = !(m_axis_tvalid && (decision == cbg_pkg::DecDown)) ||
                        (new_kbps >= floor_rate);

  // Steps up are only taken on a healthy link.
  assign up_healthy = !(m_axis_tvalid && (decision == cbg_pkg::DecUp)) ||
                      (link_state == cbg_pkg::LinkHealthy);

  // Break events agree with the reported link state.
  assign event_consistent = !m_axis_tvalid ||
    (((break_event != cbg_pkg::EvEnter) || (link_state == cbg_pkg::LinkBreaking)) &&
     ((break_event != cbg_pkg::EvExit) || (link_state != cbg_pkg::LinkBreaking)));

  `CBGU_ASSERT_NEXT(a_valid_holds, stalled, m_axis_tvalid, "result beat dropped while stalled")

  `CBGU_ASSERT(a_down_above_floor, down_clamped, "step down below floor")

  `CBGU_ASSERT(a_up_when_healthy, up_healthy, "step up outside healthy state")

  `CBGU_ASSERT(a_event_matches_state, event_consistent, "break event disagrees with link state")

endmodule

bind congestion_bitrate_governor_unit cbg_checker u_cbg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/congestion_bitrate_governor_unit_tb.sv @@
`timescale 1ns / 1ps
module congestion_bitrate_governor_unit_tb;
  import cbg_pkg::*;

  // The command code 3 has no meaning; the governor must leave its state alone.
  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned MaxPrinted = 60;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [RateBits-1:0]    cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [InUserBits-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;

  congestion_bitrate_governor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Governor mirror: configuration, link state, floor and the millisecond timers.
  cfg_t       gov_cfg;
  logic [2:0] link_q;
  rate_t      floor_q;
  stamp_t     last_down_ms, last_up_ms, healthy_since, break_since;
  logic       break_flagged;

  res_t pending_verdicts[$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned sender_idle_pct, sink_stall_pct;

  // Traffic generator state.
  stamp_t      clock_ms;
  rate_t       link_ceiling, link_nominal, applied_kbps;
  int unsigned cong_mode, ms_lo, ms_hi;

  function automatic stamp_t ms_since(stamp_t now, stamp_t then);
    stamp_t gap;
    gap = now - then;
    return gap;
  endfunction

  function automatic void reset_governor_mirror();
    gov_cfg       = CfgReset;
    link_q        = LinkIdle;
    floor_q       = '0;
    last_down_ms  = '0;
    last_up_ms    = '0;
    healthy_since = '0;
    break_since   = '0;
    break_flagged = 1'b0;
  endfunction

  // Works out the verdict for one beat and advances the mirrored state.
  function automatic res_t govern_rate(item_t it);
    res_t        r;
    rate_t       cur;
    rate_t       step;
    int unsigned fl, sum;
    logic [2:0]  nxt;
    logic        hot, severe, low_rate, down_ok, up_ok;
    cur  = (it.encoder_kbps != '0) ? it.encoder_kbps : it.encoder_nominal_kbps;
    step = RateBits'(gov_cfg.step);
    r.decision    = DecHold;
    r.new_kbps    = cur;
    r.break_event = EvNone;
    case (it.cmd)
      CmdStart: begin
        last_down_ms  = '0;
        last_up_ms    = '0;
        healthy_since = it.now_ms;
        break_since   = '0;
        break_flagged = 1'b0;
        link_q        = LinkHealthy;
      end
      CmdStop: begin
        link_q = LinkIdle;
      end
      CmdPoll: begin
        // Without a ceiling the previous floor stays in force.
        if (it.ceiling_kbps != '0) begin
          fl = 32'(it.ceiling_kbps >> 1);
          if (fl < 32'(gov_cfg.lower_floor)) fl = 32'(gov_cfg.lower_floor);
          if (fl < 32'(MinFloor)) fl = 32'(MinFloor);
          floor_q = fl[RateBits-1:0];
        end
        hot      = it.congestion >= gov_cfg.degrade_thr;
        severe   = it.congestion >= gov_cfg.break_thr;
        low_rate = cur <= floor_q;
        if (link_q == LinkIdle) begin
          nxt = LinkHealthy;
          healthy_since = it.now_ms;
        end else if (severe && low_rate) begin
          if (break_since == '0) break_since = it.now_ms;
          nxt = (ms_since(it.now_ms, break_since) >= stamp_t'(gov_cfg.break_hold))
                ? LinkBreaking : LinkAtFloor;
        end else begin
          break_since = '0;
          if (low_rate && hot) nxt = LinkAtFloor;
          else if (hot) nxt = LinkDegrading;
          else nxt = LinkHealthy;
        end
        link_q = nxt;

        if (it.adapt_enable && it.ceiling_kbps != '0) begin
          // A stored time of zero counts as never set, so the interval has passed.
          down_ok = last_down_ms == '0 ||
                    ms_since(it.now_ms, last_down_ms) >= stamp_t'(gov_cfg.down_ivl);
          up_ok   = last_up_ms == '0 ||
                    ms_since(it.now_ms, last_up_ms) >= stamp_t'(gov_cfg.up_ivl);
          if (nxt != LinkHealthy && cur > floor_q && down_ok) begin
            r.new_kbps   = (cur - floor_q > step) ? cur - step : floor_q;
            r.decision   = DecDown;
            last_down_ms = it.now_ms;
          end else if (nxt == LinkHealthy && cur < it.ceiling_kbps) begin
            if (healthy_since == '0) healthy_since = it.now_ms;
            if (ms_since(it.now_ms, healthy_since) >= stamp_t'(gov_cfg.recovery) && up_ok) begin
              sum        = 32'(cur) + 32'(step);
              r.new_kbps = (sum > 32'(it.ceiling_kbps)) ? it.ceiling_kbps : sum[RateBits-1:0];
              r.decision = DecUp;
              last_up_ms = it.now_ms;
            end
          end else if (nxt != LinkHealthy) begin
            healthy_since = '0;
          end
        end

        if (nxt == LinkBreaking && !break_flagged) begin
          break_flagged = 1'b1;
          r.break_event = EvEnter;
        end else if (nxt != LinkBreaking && break_flagged) begin
          break_flagged = 1'b0;
          r.break_event = EvExit;
        end
      end
      default: ;
    endcase
    r.link_state     = link_q;
    r.floor_kbps_out = floor_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // Predicts on each accepted input beat, checks each accepted result beat.
  always @(posedge clk_i) begin : monitor
    item_t seen;
    res_t  got, want;
    logic  moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved                     = 1'b1;
        seen.cmd                  = s_axis_tuser;
        seen.now_ms               = s_axis_tdata[31:0];
        seen.congestion           = s_axis_tdata[47:32];
        seen.ceiling_kbps         = s_axis_tdata[65:48];
        seen.encoder_kbps         = s_axis_tdata[83:66];
        seen.encoder_nominal_kbps = s_axis_tdata[101:84];
        seen.adapt_enable         = s_axis_tdata[102];
        want = govern_rate(seen);
        pending_verdicts.push_back(want);
        applied_kbps = want.new_kbps;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved              = 1'b1;
        got.link_state     = m_axis_tdata[2:0];
        got.decision       = m_axis_tdata[4:3];
        got.new_kbps       = m_axis_tdata[22:5];
        got.floor_kbps_out = m_axis_tdata[40:23];
        got.break_event    = m_axis_tdata[42:41];
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected result beat, link_state", got.link_state, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.link_state != want.link_state)
            report_mismatch("link_state", got.link_state, want.link_state);
          if (got.decision != want.decision)
            report_mismatch("decision", got.decision, want.decision);
          if (got.new_kbps != want.new_kbps)
            report_mismatch("new_kbps", got.new_kbps, want.new_kbps);
          if (got.floor_kbps_out != want.floor_kbps_out)
            report_mismatch("floor_kbps_out", got.floor_kbps_out, want.floor_kbps_out);
          if (got.break_event != want.break_event)
            report_mismatch("break_event", got.break_event, want.break_event);
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_stall_pct == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Called and returns at a falling edge; tvalid is left high on return.
  task automatic send_beat(input item_t it);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {1'b0, it.adapt_enable, it.encoder_nominal_kbps, it.encoder_kbps,
                      it.ceiling_kbps, it.congestion, it.now_ms};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [1:0] cmd, input stamp_t now,
                             input int unsigned cong, input int unsigned ceil,
                             input int unsigned enc, input int unsigned nom,
                             input logic en);
    item_t it;
    it.cmd                  = cmd;
    it.now_ms               = now;
    it.congestion           = cong[LevelBits-1:0];
    it.ceiling_kbps         = ceil[RateBits-1:0];
    it.encoder_kbps         = enc[RateBits-1:0];
    it.encoder_nominal_kbps = nom[RateBits-1:0];
    it.adapt_enable         = en;
    send_beat(it);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[RateBits-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CfgLowerFloor: gov_cfg.lower_floor = value[RateBits-1:0];
      CfgDegradeThr: gov_cfg.degrade_thr = value[15:0];
      CfgBreakThr:   gov_cfg.break_thr   = value[15:0];
      CfgBreakHold:  gov_cfg.break_hold  = value[15:0];
      CfgDownIvl:    gov_cfg.down_ivl    = value[15:0];
      CfgUpIvl:      gov_cfg.up_ivl      = value[15:0];
      CfgRecovery:   gov_cfg.recovery    = value[15:0];
      default:       gov_cfg.step        = value[15:0];
    endcase
  endtask

  task automatic write_all_regs(input int unsigned lower, input int unsigned deg,
                                input int unsigned brk, input int unsigned hold,
                                input int unsigned down, input int unsigned up,
                                input int unsigned rec, input int unsigned step);
    write_reg(CfgLowerFloor, lower);
    write_reg(CfgDegradeThr, deg);
    write_reg(CfgBreakThr, brk);
    write_reg(CfgBreakHold, hold);
    write_reg(CfgDownIvl, down);
    write_reg(CfgUpIvl, up);
    write_reg(CfgRecovery, rec);
    write_reg(CfgStep, step);
  endtask

  // Lowers tvalid and waits until every result is back and the pipeline is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly a live stream: polls with a drifting congestion level and the encoder
  // following the last decision, with starts, stops and odd fields mixed in.
  task automatic send_stream_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) it.cmd = CmdStart;
    else if (pick < 5) it.cmd = CmdStop;
    else if (pick < 6) it.cmd = CmdUnknown;
    else it.cmd = CmdPoll;

    case ($urandom_range(29))
      0: clock_ms = clock_ms;
      1: clock_ms = $urandom();
      2: clock_ms = 32'hFFFF_FFFF - $urandom_range(5000);
      3: clock_ms = '0;
      default: clock_ms = clock_ms + $urandom_range(ms_hi, ms_lo);
    endcase
    it.now_ms = clock_ms;

    if ($urandom_range(9) == 0) cong_mode = $urandom_range(2);
    case (cong_mode)
      0: it.congestion = LevelBits'($urandom_range(12000));
      1: it.congestion = LevelBits'($urandom_range(32768, 12000));
      default: it.congestion = LevelBits'($urandom_range(32768, 28000));
    endcase
    if ($urandom_range(19) == 0) it.congestion = LevelBits'($urandom_range(65535));

    if (it.cmd == CmdStart) begin
      link_ceiling = RateBits'($urandom_range(12000, 400));
      link_nominal = RateBits'($urandom_range(link_ceiling, 100));
      applied_kbps = ($urandom_range(1) == 0) ? '0
                                              : RateBits'($urandom_range(link_ceiling, 100));
    end

    pick = $urandom_range(99);
    if (pick < 6) it.ceiling_kbps = '0;
    else if (pick < 10) it.ceiling_kbps = RateBits'($urandom_range(262143));
    else it.ceiling_kbps = link_ceiling;

    pick = $urandom_range(99);
    if (pick < 8) it.encoder_kbps = '0;
    else if (pick < 15) it.encoder_kbps = RateBits'($urandom_range(262143));
    else it.encoder_kbps = applied_kbps;

    it.encoder_nominal_kbps = ($urandom_range(9) == 0) ? RateBits'($urandom_range(262143))
                                                       : link_nominal;
    it.adapt_enable = ($urandom_range(99) < 92);
    send_beat(it);
  endtask

  task automatic run_traffic(input int unsigned count, input int unsigned lo,
                             input int unsigned hi);
    ms_lo = lo;
    ms_hi = hi;
    repeat (count) send_stream_item();
  endtask

  task automatic test_edge_cases();
    stamp_t t;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_fields(CmdUnknown, 32'd5, 0, 0, 0, 0, 1'b0);
    send_fields(CmdPoll, 32'd1000, 0, 0, 0, 0, 1'b1);
    // A step-down at time zero leaves its timer unset, so the next one is allowed.
    send_fields(CmdPoll, 32'd0, 32768, 262143, 262143, 262143, 1'b1);
    send_fields(CmdPoll, 32'd100, 32768, 262143, 0, 261643, 1'b1);
    // Recovery time measured across the wrap of the millisecond counter.
    send_fields(CmdStart, 32'hFFFF_FFF0, 0, 8000, 5000, 6000, 1'b1);
    send_fields(CmdPoll, 32'h0000_2700, 0, 8000, 5000, 6000, 1'b1);
    send_fields(CmdPoll, 32'h0000_2800, 0, 8000, 5500, 6000, 1'b1);
    send_fields(CmdPoll, 32'h0000_3000, 65535, 8000, 5500, 6000, 1'b0);
    send_fields(CmdPoll, 32'h0000_3100, 20000, 0, 5500, 6000, 1'b1);
    t = 32'h0000_4000;
    send_fields(CmdPoll, t, 32768, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 3000, 32768, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 3100, 32768, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 3200, 0, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 3300, 32768, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 6300, 32768, 8000, 4000, 0, 1'b1);
    // A stream restart while breaking clears the flag without an exit event.
    send_fields(CmdStart, t + 6400, 32768, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 6500, 0, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 6600, 0, 1, 262143, 0, 1'b1);
    send_fields(CmdStop, t + 6700, 0, 8000, 4000, 0, 1'b1);
    send_fields(CmdPoll, t + 6800, 0, 8000, 6000, 0, 1'b1);
    send_fields(CmdPoll, t + 12800, 16384, 8000, 6000, 0, 1'b1);
    send_fields(CmdPoll, t + 12900, 16383, 8000, 5500, 0, 1'b1);
    clock_ms = t + 12900;
    drain();
  endtask

  task automatic test_default_profile();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    run_traffic(90, 200, 3000);
    drain();
  endtask

  task automatic test_fast_timers();
    write_all_regs(1500, 12000, 26000, 0, 0, 0, 0, 250);
    sender_idle_pct = 83;
    sink_stall_pct  = 0;
    run_traffic(90, 50, 800);
    drain();
  endtask

  // Largest settings, degrade threshold at 1.0; the break threshold lies above 1.0 and is compared as an integer.
  task automatic test_slow_timers();
    write_all_regs(262143, 32768, 65535, 65535, 65535, 65535, 65535, 65535);
    sender_idle_pct = 0;
    sink_stall_pct  = 83;
    run_traffic(80, 1000, 40000);
    drain();
  endtask

  task automatic test_random_settings();
    int unsigned deg;
    sender_idle_pct = 10;
    sink_stall_pct  = 10;
    repeat (4) begin
      deg = $urandom_range(32768);
      write_all_regs($urandom_range(8000), deg,
                     ($urandom_range(4) == 0) ? $urandom_range(65535)
                                              : $urandom_range(32768, deg),
                     $urandom_range(6000), $urandom_range(6000), $urandom_range(6000),
                     $urandom_range(12000), $urandom_range(2000));
      run_traffic(35, 50, 3000);
      drain();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgLowerFloor;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = CmdPoll;
    m_axis_tready   = 1'b0;
    error_count     = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    clock_ms        = '0;
    link_ceiling    = 18'd6000;
    link_nominal    = 18'd5000;
    applied_kbps    = 18'd6000;
    cong_mode       = 0;
    ms_lo           = 200;
    ms_hi           = 3000;
    reset_governor_mirror();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_edge_cases();
    test_default_profile();
    test_fast_timers();
    test_slow_timers();
    test_random_settings();

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
